/* hw/rtl/sops_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the soft-off power supervisor.
// No dependencies; every module imports this package.
package sops_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_PIN    = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    // Pin function codes
    localparam logic [2:0] FN_OFF       = 3'd0;
    localparam logic [2:0] FN_LVL_RST   = 3'd1;
    localparam logic [2:0] FN_EDGE_RST  = 3'd2;
    localparam logic [2:0] FN_LVL_OFF   = 3'd3;
    localparam logic [2:0] FN_EDGE_OFF  = 3'd4;
    localparam logic [2:0] FN_UNDERVOLT = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_INACT_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_FN      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUX_FN      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_DEAD    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AUX_DEAD    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UV_THRESH   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UV_LIMIT    = 4'd7;

    localparam logic [7:0] SAT_MAX8 = 8'hFF;

    typedef struct packed {
        logic [1:0] kind;
        logic       ext_level;
        logic       aux_level;
        logic [9:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic power_off;
        logic sample_request;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          value;
    } t_cfg_beat;

    // Current register set
    typedef struct packed {
        logic [31:0] inactivity_limit_seconds;
        logic [2:0]  ext_pin_function;
        logic [2:0]  aux_pin_function;
        logic [1:0]  pin_polarity;
        logic [7:0]  ext_deadtime_ticks;
        logic [7:0]  aux_deadtime_ticks;
        logic [9:0]  undervoltage_threshold;
        logic [7:0]  undervoltage_count_limit;
    } t_cfg_regs;

endpackage

/* hw/rtl/sops_chan_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is a parameter; types come from sops_pkg.
interface sops_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/sops_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file of the soft-off power supervisor.
// Depends on sops_pkg and sops_chan_if.
module sops_cfg_regs
    import sops_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sops_chan_if.sink i_cfg,
    output t_cfg_regs o_regs
);

    t_cfg_regs r_regs;
    t_cfg_regs n_regs;

    // Writes are taken at any time
    assign i_cfg.ready = 1'b1;

    // Decode the write beat; unknown indexes are dropped
    always_comb begin
        n_regs = r_regs;
        if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_INACT_LIMIT: n_regs.inactivity_limit_seconds = i_cfg.data.value;
                REG_EXT_FN:      n_regs.ext_pin_function = i_cfg.data.value[2:0];
                REG_AUX_FN:      n_regs.aux_pin_function = i_cfg.data.value[2:0];
                REG_POLARITY:    n_regs.pin_polarity = i_cfg.data.value[1:0];
                REG_EXT_DEAD:    n_regs.ext_deadtime_ticks = i_cfg.data.value[7:0];
                REG_AUX_DEAD:    n_regs.aux_deadtime_ticks = i_cfg.data.value[7:0];
                REG_UV_THRESH:   n_regs.undervoltage_threshold = i_cfg.data.value[9:0];
                REG_UV_LIMIT:    n_regs.undervoltage_count_limit = i_cfg.data.value[7:0];
                default:         n_regs = r_regs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.inactivity_limit_seconds <= 32'd60;
            r_regs.ext_pin_function         <= FN_UNDERVOLT;
            r_regs.aux_pin_function         <= FN_LVL_OFF;
            r_regs.pin_polarity             <= 2'd2;
            r_regs.ext_deadtime_ticks       <= 8'd0;
            r_regs.aux_deadtime_ticks       <= 8'd2;
            r_regs.undervoltage_threshold   <= 10'd879;
            r_regs.undervoltage_count_limit <= 8'd6;
        end else begin
            r_regs <= n_regs;
        end
    end

    assign o_regs = r_regs;

endmodule

/* hw/rtl/sops_step.sv */
`timescale 1ns / 1ps
// Supervisor state and the single-pass update for one input item.
// Depends on sops_pkg.
module sops_step
    import sops_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg_regs i_regs,
    output t_out_item o_result
);

    localparam int unsigned PHASE_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [PHASE_W:0] PHASE_END = (PHASE_W+1)'(TICKS_PER_SECOND);

    logic [PHASE_W-1:0] r_phase,    n_phase;
    logic [31:0]        r_inactive, n_inactive;
    logic [7:0]         r_startup,  n_startup;
    logic [7:0]         r_low_cnt,  n_low_cnt;
    logic               r_off,      n_off;

    logic [PHASE_W:0] phase_inc;
    logic [31:0]      inactive_inc;
    logic [7:0]       low_cnt_inc;
    logic             second_done;
    logic             do_pins;
    logic             ext_on;
    logic             aux_on;
    logic             ext_clr, ext_kill, aux_clr, aux_kill;
    logic             request;

    assign phase_inc    = {1'b0, r_phase} + (PHASE_W+1)'(1);
    assign second_done  = (phase_inc >= PHASE_END);
    assign inactive_inc = r_inactive + 32'd1;
    assign low_cnt_inc  = (r_low_cnt == SAT_MAX8) ? r_low_cnt : r_low_cnt + 8'd1;

    // Pin qualification uses the start-up count before this tick advances it
    assign ext_on = (r_startup >= i_regs.ext_deadtime_ticks)
                  && (i_item.ext_level ^ i_regs.pin_polarity[0]);
    assign aux_on = (r_startup >= i_regs.aux_deadtime_ticks)
                  && (i_item.aux_level ^ i_regs.pin_polarity[1]);

    // Decode pin actions
    always_comb begin
        ext_clr  = 1'b0;
        ext_kill = 1'b0;
        aux_clr  = 1'b0;
        aux_kill = 1'b0;
        case (i_regs.ext_pin_function) inside
            FN_LVL_RST, FN_EDGE_RST: ext_clr  = ext_on;
            FN_LVL_OFF, FN_EDGE_OFF: ext_kill = ext_on;
            default: ;
        endcase
        case (i_regs.aux_pin_function) inside
            FN_LVL_RST, FN_EDGE_RST: aux_clr  = aux_on;
            FN_LVL_OFF, FN_EDGE_OFF: aux_kill = aux_on;
            default: ;
        endcase
    end

    // Next state for one item
    always_comb begin
        n_phase    = r_phase;
        n_inactive = r_inactive;
        n_startup  = r_startup;
        n_low_cnt  = r_low_cnt;
        n_off      = r_off;
        request    = 1'b0;
        do_pins    = 1'b0;
        if (!r_off) begin
            case (i_item.kind)
                KIND_TICK: begin
                    if (second_done) begin
                        n_phase    = '0;
                        n_inactive = inactive_inc;
                        request    = (i_regs.ext_pin_function == FN_UNDERVOLT);
                        if (inactive_inc > i_regs.inactivity_limit_seconds) begin
                            n_off = 1'b1;
                        end else begin
                            do_pins = 1'b1;
                        end
                    end else begin
                        n_phase = phase_inc[PHASE_W-1:0];
                    end
                    if (r_startup != SAT_MAX8) begin
                        n_startup = r_startup + 8'd1;
                    end
                end
                KIND_PIN: begin
                    do_pins = 1'b1;
                end
                KIND_SAMPLE: begin
                    if (i_item.sample_value < i_regs.undervoltage_threshold) begin
                        n_low_cnt = low_cnt_inc;
                        if (low_cnt_inc >= i_regs.undervoltage_count_limit) begin
                            n_off = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            // External pin acts first; aux only if still running
            if (do_pins) begin
                if (ext_clr || (!ext_kill && aux_clr)) begin
                    n_inactive = '0;
                end
                if (ext_kill || aux_kill) begin
                    n_off = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_inactive <= '0;
            r_startup  <= '0;
            r_low_cnt  <= '0;
            r_off      <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_inactive <= n_inactive;
            r_startup  <= n_startup;
            r_low_cnt  <= n_low_cnt;
            r_off      <= n_off;
        end
    end

    assign o_result.power_off      = n_off;
    assign o_result.sample_request = request && !n_off;

endmodule

/* hw/rtl/soft_off_power_supervisor.sv */
`timescale 1ns / 1ps
// Soft-off power supervisor, top level.
// An accepted input beat passes through the input register, then the result
// register, to its result beat. Throughput: one item per cycle while o_out.ready
// is high. Synchronous active-low reset clears all state but the payload registers,
// restores register defaults and empties both pipeline stages.
module soft_off_power_supervisor
    import sops_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sops_chan_if.sink   i_in,
    sops_chan_if.source o_out,
    sops_chan_if.sink   i_cfg
);

    t_cfg_regs cfg_regs;
    t_out_item step_result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic step_fire;

    // Advance the input stage when the result register is free or draining
    assign step_fire  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step_fire;

    sops_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (cfg_regs)
    );

    sops_step #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (step_fire),
        .i_item   (r_in_item),
        .i_regs   (cfg_regs),
        .o_result (step_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    // Result register: hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out_item <= step_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule
